// ===== sv/smv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package smv_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] EXP_MAX = 11'h7FF;
  localparam logic [63:0] POS_ZERO = 64'h0;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_NONZERO = 2'd1,
    REQ_EMPTY   = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ADD_IDLE,
    ADD_ALIGN,
    ADD_SUM,
    ADD_COUNT,
    ADD_ROUND
  } add_state_t;

  // one queued item: matrix value and the vector element it meets
  typedef struct packed {
    logic        is_empty;
    logic        row_end;
    logic [63:0] mat;
    logic [63:0] vec;
  } smv_item_t;

  typedef struct packed {
    logic        is_empty;
    logic        row_end;
    logic [63:0] prod;
  } smv_prod_t;

  // round to nearest even and pack; a mantissa carry walks into the exponent
  function automatic logic [63:0] round_pack(input logic sgn, input logic [12:0] e_pre,
                                             input logic [52:0] mant, input logic g,
                                             input logic st);
    logic        inc;
    logic [64:0] total;
    logic [63:0] res;
    inc   = g & (st | mant[0]);
    total = {e_pre, 52'b0} + {12'b0, mant} + {64'b0, inc};
    if (total[64:52] >= {2'b0, EXP_MAX}) begin
      res = {sgn, EXP_MAX, 52'b0};
    end else begin
      res = {sgn, total[62:0]};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== sv/smv_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smv_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                  wdata,
  input  wire logic                              re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/smv_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smv_front #(
  parameter int unsigned MAX_ROWS = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        req_type,
  input  wire logic [11:0]       position,
  input  wire logic [63:0]       payload,
  input  wire logic              row_end,
  output logic                   push,
  output smv_pkg::smv_item_t     push_item,
  input  wire logic              queue_full
);
  import smv_pkg::*;

  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic          accept;
  logic          pos_ok;
  logic [31:0]   pos_wide;
  logic [AW-1:0] addr;
  logic          is_load;
  logic          is_nz;
  logic          is_empty;
  logic [63:0]   vec_rd;

  logic          hold_valid;
  logic          hold_empty;
  logic          hold_end;
  logic          hold_pos_ok;
  logic [63:0]   hold_mat;

  assign pos_wide = {20'b0, position};
  assign addr     = pos_wide[AW-1:0];
  assign pos_ok   = pos_wide < MAX_ROWS;
  assign is_load  = req_type == REQ_LOAD;
  assign is_nz    = req_type == REQ_NONZERO;
  assign is_empty = req_type == REQ_EMPTY;

  assign in_stall = hold_valid & queue_full;
  assign accept   = in_valid & ~in_stall;
  assign push     = hold_valid & ~queue_full;

  smv_ram #(.WIDTH(64), .DEPTH(MAX_ROWS)) u_vec (
    .clk   (clk),
    .we    (accept & is_load & pos_ok),
    .waddr (addr),
    .wdata (payload),
    .re    (accept & is_nz),
    .raddr (addr),
    .rdata (vec_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept && (is_nz || is_empty)) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (is_nz || is_empty)) begin
      hold_empty  <= is_empty;
      hold_end    <= row_end;
      hold_pos_ok <= pos_ok;
      hold_mat    <= payload;
    end
  end

  // out-of-range column reads as +0.0
  always_comb begin
    push_item.is_empty = hold_empty;
    push_item.row_end  = hold_end;
    push_item.mat      = hold_mat;
    push_item.vec      = hold_pos_ok ? vec_rd : POS_ZERO;
  end

endmodule
`default_nettype wire

// ===== sv/smv_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smv_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  smv_pkg::smv_item_t push_item,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output smv_pkg::smv_item_t head
);
  import smv_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  smv_item_t   entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full      = count == (PW+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== sv/smv_fmul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smv_fmul (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  smv_pkg::smv_item_t in_item,
  output logic               advance,
  output logic               out_valid,
  output smv_pkg::smv_prod_t out_prod,
  input  wire logic          out_take
);
  import smv_pkg::*;

  // stage 1: unpack, four partial products
  logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic [10:0] ea, eb, ea_e, eb_e;
  logic [52:0] ma, mb;

  logic              v1, v2, v3, v4;
  logic              empty1, end1, sgn1, nan1, inf1, zero1;
  logic signed [12:0] es1;
  logic [51:0]       p_hh;
  logic [52:0]       p_hl, p_lh;
  logic [53:0]       p_ll;

  logic              empty2, end2, sgn2, nan2, inf2, zero2;
  logic signed [12:0] es2;
  logic [105:0]      prod2;

  logic              empty3, end3, sgn3, nan3, inf3, zero3;
  logic signed [12:0] es3;
  logic [105:0]      prod3;
  logic [6:0]        lz3;

  logic [6:0]        lz_c;
  logic [105:0]      sum_c;
  logic [105:0]      norm;
  logic [105:0]      mask;
  logic [12:0]       e_pre;
  logic              sticky_x;
  logic [6:0]        rshift;
  logic signed [12:0] neg_es;
  logic [63:0]       res_c;

  assign advance = ~v4 | out_take;

  always_comb begin
    ea     = in_item.mat[62:52];
    eb     = in_item.vec[62:52];
    ea_e   = {ea[10:1], ea[0] | ~|ea};
    eb_e   = {eb[10:1], eb[0] | ~|eb};
    ma     = {|ea, in_item.mat[51:0]};
    mb     = {|eb, in_item.vec[51:0]};
    a_nan  = (ea == EXP_MAX) && (in_item.mat[51:0] != '0);
    a_inf  = (ea == EXP_MAX) && (in_item.mat[51:0] == '0);
    a_zero = (ea == '0) && (in_item.mat[51:0] == '0);
    b_nan  = (eb == EXP_MAX) && (in_item.vec[51:0] != '0);
    b_inf  = (eb == EXP_MAX) && (in_item.vec[51:0] == '0);
    b_zero = (eb == '0) && (in_item.vec[51:0] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      empty1 <= in_item.is_empty;
      end1   <= in_item.row_end;
      sgn1   <= in_item.mat[63] ^ in_item.vec[63];
      nan1   <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      inf1   <= (a_inf | b_inf) & ~(a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero));
      zero1  <= (a_zero | b_zero) & ~(a_nan | b_nan | a_inf | b_inf);
      es1    <= $signed({2'b0, ea_e}) + $signed({2'b0, eb_e}) - 13'sd1023;
      p_hh   <= ma[52:27] * mb[52:27];
      p_hl   <= 53'(ma[52:27]) * 53'(mb[26:0]);
      p_lh   <= 53'(ma[26:0]) * 53'(mb[52:27]);
      p_ll   <= ma[26:0] * mb[26:0];
    end
  end

  // stage 2: sum the partials into the full 106-bit product
  always_ff @(posedge clk) begin
    if (advance) begin
      empty2 <= empty1;
      end2   <= end1;
      sgn2   <= sgn1;
      nan2   <= nan1;
      inf2   <= inf1;
      zero2  <= zero1;
      es2    <= es1;
      prod2  <= {p_hh, 54'b0} + {26'b0, p_hl, 27'b0} + {26'b0, p_lh, 27'b0}
                + {52'b0, p_ll};
    end
  end

  // stage 3: leading zero count
  always_comb begin
    lz_c = 7'd106;
    for (int i = 0; i < 106; i++) begin
      if (prod2[i]) begin
        lz_c = 7'(105 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      empty3 <= empty2;
      end3   <= end2;
      sgn3   <= sgn2;
      nan3   <= nan2;
      inf3   <= inf2;
      zero3  <= zero2;
      es3    <= es2;
      prod3  <= prod2;
      lz3    <= lz_c;
    end
  end

  // stage 4: normalize (or denormalize) and round
  always_comb begin
    neg_es   = -es3;
    rshift   = (neg_es > 13'sd127) ? 7'd127 : neg_es[6:0];
    mask     = ~({106{1'b1}} << rshift);
    sticky_x = 1'b0;
    if (es3 >= $signed({6'b0, lz3})) begin
      norm  = prod3 << lz3;
      e_pre = 13'(es3 - $signed({6'b0, lz3}));
    end else if (es3 >= 13'sd0) begin
      norm  = prod3 << es3[6:0];
      e_pre = '0;
    end else begin
      norm     = prod3 >> rshift;
      sticky_x = |(prod3 & mask);
      e_pre    = '0;
    end
    sum_c = norm;
    if (nan3) begin
      res_c = CANON_NAN;
    end else if (inf3) begin
      res_c = {sgn3, EXP_MAX, 52'b0};
    end else if (zero3) begin
      res_c = {sgn3, 63'b0};
    end else begin
      res_c = round_pack(sgn3, e_pre, sum_c[105:53], sum_c[52], (|sum_c[51:0]) | sticky_x);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_prod.is_empty <= empty3;
      out_prod.row_end  <= end3;
      out_prod.prod     <= res_c;
    end
  end

  assign out_valid = v4;

endmodule
`default_nettype wire

// ===== sv/smv_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smv_back #(
  parameter int unsigned MAX_ROWS = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [12:0]   row_count,
  input  wire logic          mul_valid,
  input  smv_pkg::smv_prod_t mul_prod,
  output logic               take,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [11:0]        row_number,
  output logic [63:0]        row_sum,
  output logic               last_row
);
  import smv_pkg::*;

  add_state_t state, state_next;

  logic [63:0] acc;
  logic [63:0] p_reg;
  logic        p_empty;
  logic        p_end;
  logic [12:0] current_row;

  logic        out_free;
  logic        closes_row;
  logic        finish_ok;
  logic        emit;
  logic        finish;

  // align stage
  logic        x_nan, x_inf, y_nan, y_inf;
  logic        swap;
  logic [63:0] big, small_op;
  logic [10:0] eb_e, es_e, dexp;
  logic [5:0]  dd;
  logic [55:0] mbig, msmall, msh;
  logic        st_al;

  logic [55:0] a_big, a_small;
  logic [10:0] a_exp;
  logic        a_sign, a_sub, a_neg0, a_nan, a_inf, a_inf_sign;

  logic [56:0] s_sum;
  logic [10:0] s_exp;
  logic        s_sign, s_neg0, s_nan, s_inf, s_inf_sign;

  logic [5:0]  lz_c;
  logic [5:0]  c_lz;
  logic [56:0] c_sum;
  logic [10:0] c_exp;
  logic        c_sign, c_neg0, c_nan, c_inf, c_inf_sign;

  logic [5:0]  shamt;
  logic [56:0] norm;
  logic [10:0] e_pre;
  logic [63:0] sum_c;

  logic [13:0] rows_eff;
  logic        last;

  assign out_free   = ~out_valid | ~out_stall;
  assign closes_row = p_empty | p_end;

  always_comb begin
    state_next = state;
    case (state)
      ADD_IDLE:  if (mul_valid) state_next = ADD_ALIGN;
      ADD_ALIGN: state_next = ADD_SUM;
      ADD_SUM:   state_next = ADD_COUNT;
      ADD_COUNT: state_next = ADD_ROUND;
      ADD_ROUND: begin
        if (finish_ok) begin
          state_next = mul_valid ? ADD_ALIGN : ADD_IDLE;
        end
      end
      default:   state_next = ADD_IDLE;
    endcase
  end

  always_comb begin
    finish_ok = ~closes_row | out_free;
    finish    = 1'b0;
    take      = 1'b0;
    emit      = 1'b0;
    case (state)
      ADD_IDLE:  take = mul_valid;
      ADD_ROUND: begin
        finish = finish_ok;
        take   = finish_ok & mul_valid;
        emit   = finish_ok & closes_row;
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ADD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_reg   <= mul_prod.prod;
      p_empty <= mul_prod.is_empty;
      p_end   <= mul_prod.row_end;
    end
  end

  // align: larger magnitude is the base, the smaller one shifts right with sticky
  always_comb begin
    x_nan    = (acc[62:52] == EXP_MAX) && (acc[51:0] != '0);
    x_inf    = (acc[62:52] == EXP_MAX) && (acc[51:0] == '0);
    y_nan    = (p_reg[62:52] == EXP_MAX) && (p_reg[51:0] != '0);
    y_inf    = (p_reg[62:52] == EXP_MAX) && (p_reg[51:0] == '0);
    swap     = p_reg[62:0] > acc[62:0];
    big      = swap ? p_reg : acc;
    small_op = swap ? acc : p_reg;
    eb_e     = {big[62:53], big[52] | ~|big[62:52]};
    es_e     = {small_op[62:53], small_op[52] | ~|small_op[62:52]};
    dexp     = eb_e - es_e;
    dd       = (dexp >= 11'd63) ? 6'd63 : dexp[5:0];
    mbig     = {|big[62:52], big[51:0], 3'b0};
    msmall   = {|small_op[62:52], small_op[51:0], 3'b0};
    msh      = msmall >> dd;
    st_al    = |(msmall & ~({56{1'b1}} << dd));
  end

  always_ff @(posedge clk) begin
    a_big      <= mbig;
    a_small    <= {msh[55:1], msh[0] | st_al};
    a_exp      <= eb_e;
    a_sign     <= big[63];
    a_sub      <= acc[63] ^ p_reg[63];
    a_neg0     <= acc[63] & p_reg[63];
    a_nan      <= x_nan | y_nan | (x_inf & y_inf & (acc[63] ^ p_reg[63]));
    a_inf      <= (x_inf | y_inf) & ~(x_nan | y_nan | (x_inf & y_inf & (acc[63] ^ p_reg[63])));
    a_inf_sign <= x_inf ? acc[63] : p_reg[63];
  end

  always_ff @(posedge clk) begin
    s_sum      <= a_sub ? ({1'b0, a_big} - {1'b0, a_small}) : ({1'b0, a_big} + {1'b0, a_small});
    s_exp      <= a_exp;
    s_sign     <= a_sign;
    s_neg0     <= a_neg0;
    s_nan      <= a_nan;
    s_inf      <= a_inf;
    s_inf_sign <= a_inf_sign;
  end

  always_comb begin
    lz_c = 6'd57;
    for (int i = 0; i < 57; i++) begin
      if (s_sum[i]) begin
        lz_c = 6'(56 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    c_lz       <= lz_c;
    c_sum      <= s_sum;
    c_exp      <= s_exp;
    c_sign     <= s_sign;
    c_neg0     <= s_neg0;
    c_nan      <= s_nan;
    c_inf      <= s_inf;
    c_inf_sign <= s_inf_sign;
  end

  // normalize, stopping at the subnormal boundary, then round
  always_comb begin
    if ({5'b0, c_lz} <= c_exp) begin
      shamt = c_lz;
      e_pre = c_exp - {5'b0, c_lz};
    end else begin
      shamt = c_exp[5:0];
      e_pre = '0;
    end
    norm = c_sum << shamt;
    if (c_nan) begin
      sum_c = CANON_NAN;
    end else if (c_inf) begin
      sum_c = {c_inf_sign, EXP_MAX, 52'b0};
    end else if (c_sum == '0) begin
      sum_c = {c_neg0, 63'b0};
    end else begin
      sum_c = round_pack(c_sign, {2'b0, e_pre}, norm[56:4], norm[3], |norm[2:0]);
    end
  end

  always_comb begin
    if (row_count == '0) begin
      rows_eff = 14'd1;
    end else if ({19'b0, row_count} > MAX_ROWS) begin
      rows_eff = 14'(MAX_ROWS);
    end else begin
      rows_eff = {1'b0, row_count};
    end
    last = ({1'b0, current_row} + 14'd1) >= rows_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= POS_ZERO;
      current_row <= '0;
    end else if (finish) begin
      acc <= closes_row ? POS_ZERO : sum_c;
      if (closes_row) begin
        current_row <= last ? '0 : current_row + 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      row_number <= current_row[11:0];
      row_sum    <= p_empty ? POS_ZERO : sum_c;
      last_row   <= last;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sparse_matrix_vector_multiply.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    req_type, position, payload, row_end
// out       output     out_valid / out_stall  row_number, row_sum, last_row
// cfg       input      cfg_valid / cfg_ready  row_count
//
// Loads retire at one per cycle while in_stall is low. Nonzeros and empty rows pass a 4-stage
// double multiplier, then the accumulator loop (align, add, count, round)
// sets the rate: it takes a new nonzero or empty-row item only as it finishes rounding the last.
// A four-entry queue between the vector read and the multiplier absorbs stalls.
// Synchronous reset clears control state, the row sum and the row counter;
// the vector store is not cleared and needs no clearing pass.
module sparse_matrix_vector_multiply #(
  parameter int unsigned MAX_ROWS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [11:0] position,
  input  wire logic [63:0] payload,
  input  wire logic        row_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      row_number,
  output logic [63:0]      row_sum,
  output logic             last_row,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] row_count
);
  import smv_pkg::*;

  logic        rows_reg_valid;
  logic [12:0] rows_reg;

  logic        push;
  smv_item_t   push_item;
  logic        queue_full;
  logic        queue_not_empty;
  smv_item_t   head;
  logic        mul_advance;
  logic        mul_valid;
  smv_prod_t   mul_prod;
  logic        take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_reg       <= 13'd4096;
      rows_reg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      rows_reg       <= row_count;
      rows_reg_valid <= 1'b1;
    end
  end

  smv_front #(.MAX_ROWS(MAX_ROWS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .position   (position),
    .payload    (payload),
    .row_end    (row_end),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  smv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (queue_not_empty & mul_advance),
    .not_empty (queue_not_empty),
    .head      (head)
  );

  smv_fmul u_fmul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (queue_not_empty),
    .in_item   (head),
    .advance   (mul_advance),
    .out_valid (mul_valid),
    .out_prod  (mul_prod),
    .out_take  (take)
  );

  smv_back #(.MAX_ROWS(MAX_ROWS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .row_count  (rows_reg_valid ? rows_reg : 13'd4096),
    .mul_valid  (mul_valid),
    .mul_prod   (mul_prod),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_number (row_number),
    .row_sum    (row_sum),
    .last_row   (last_row)
  );

endmodule
`default_nettype wire

// ===== dv/smv_checker.sv =====
`timescale 1ns / 1ps
module smv_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [11:0] position,
  input  wire logic [63:0] payload,
  input  wire logic        row_end,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [11:0] row_number,
  input  wire logic [63:0] row_sum,
  input  wire logic        last_row,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [12:0] row_count,
  output int               fail_count,
  output int               pending_rows,
  output int               rows_checked
);
  import smv_pkg::*;

  typedef struct {
    logic [11:0] row;
    logic [63:0] sum;
    logic        last;
  } row_result_t;

  logic [63:0]  vec_mem [4096];
  logic [63:0]  acc_bits;
  logic [11:0]  cur_row;
  logic [12:0]  rows_reg;
  row_result_t  row_queue[$];

  function automatic logic [12:0] rows_in_use(input logic [12:0] r);
    if (r == 13'd0) return 13'd1;
    if (r > 13'd4096) return 13'd4096;
    return r;
  endfunction

  function automatic logic [63:0] canon(input logic [63:0] b);
    if (b[62:52] == EXP_MAX && b[51:0] != 52'd0) return CANON_NAN;
    return b;
  endfunction

  // emit the finished row and advance or wrap the counter
  task automatic close_row(input logic [63:0] sum);
    row_result_t r;
    logic        is_last;
    is_last = ({1'b0, cur_row} + 13'd1 >= rows_in_use(rows_reg));
    r.row = cur_row;
    r.sum = canon(sum);
    r.last = is_last;
    row_queue = {row_queue, r};
    cur_row = is_last ? 12'd0 : cur_row + 12'd1;
    acc_bits = POS_ZERO;
  endtask

  always @(posedge clk) begin : watch
    row_result_t exp_r;
    logic [63:0] prod_bits;
    if (rst) begin
      acc_bits = POS_ZERO;
      cur_row = 12'd0;
      rows_reg = 13'd4096;
      row_queue.delete();
      fail_count = 0;
      rows_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (row_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected row transaction row=%0d sum=%h last=%b",
                   $time, row_number, row_sum, last_row);
        end else begin
          exp_r = row_queue.pop_front();
          rows_checked++;
          if (row_number !== exp_r.row) begin
            fail_count++;
            $display("%0t: row_number expected %0d actual %0d", $time, exp_r.row, row_number);
          end
          if (row_sum !== exp_r.sum) begin
            fail_count++;
            $display("%0t: row_sum (row %0d) expected %h actual %h",
                     $time, exp_r.row, exp_r.sum, row_sum);
          end
          if (last_row !== exp_r.last) begin
            fail_count++;
            $display("%0t: last_row (row %0d) expected %b actual %b",
                     $time, exp_r.row, exp_r.last, last_row);
          end
        end
      end
      if (cfg_valid && cfg_ready) rows_reg = row_count;
      if (in_valid && !in_stall) begin
        case (req_kind_t'(req_type))
          REQ_LOAD: vec_mem[position] = payload;
          REQ_NONZERO: begin
            // round the product before the add: no fused multiply-add
            prod_bits = $realtobits($bitstoreal(payload) * $bitstoreal(vec_mem[position]));
            acc_bits = $realtobits($bitstoreal(acc_bits) + $bitstoreal(prod_bits));
            if (row_end) close_row(acc_bits);
          end
          REQ_EMPTY: close_row(POS_ZERO);
          default: ;
        endcase
      end
    end
    pending_rows = row_queue.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import smv_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [11:0] position;
  logic [63:0] payload;
  logic        row_end;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] row_number;
  logic [63:0] row_sum;
  logic        last_row;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_rows;

  int fail_count;
  int pending_rows;
  int rows_checked;
  int items_sent;
  int burst_left;
  bit hold_req;
  bit loaded [4096];
  int loaded_pos[$];

  sparse_matrix_vector_multiply uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .position(position), .payload(payload), .row_end(row_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .row_number(row_number), .row_sum(row_sum), .last_row(last_row),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .row_count(cfg_rows)
  );

  smv_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .position(position), .payload(payload), .row_end(row_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .row_number(row_number), .row_sum(row_sum), .last_row(last_row),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .row_count(cfg_rows),
    .fail_count(fail_count), .pending_rows(pending_rows), .rows_checked(rows_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: stall pattern changes mode at random; long hold on request
  initial begin : receiver
    int mode;
    int span;
    bit hold_done;
    out_stall = 1'b0;
    mode = 0;
    span = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(50, 300);
      end
      span--;
      case (mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 99) < 30);
        default: out_stall = ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  task automatic send_req(input req_kind_t kind, input logic [11:0] pos,
                          input logic [63:0] data, input logic endm);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid = 1'b1;
    req_type = kind;
    position = pos;
    payload = data;
    row_end = endm;
    if (kind == REQ_LOAD && !loaded[pos]) begin
      loaded[pos] = 1'b1;
      loaded_pos = {loaded_pos, int'(pos)};
    end
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_rows(input logic [12:0] v);
    in_valid = 1'b0;
    while (pending_rows != 0) @(negedge clk);
    // a nonzero without row end may still be in the adder loop
    repeat (80) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_rows = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [63:0] rand_double();
    logic [63:0] b;
    b = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: b[62:52] = 11'(1023 - 30 + $urandom_range(0, 60));
      6: ;
      7: case ($urandom_range(0, 6))
           0: b = 64'h0;
           1: b = 64'h8000_0000_0000_0000;
           2: b = 64'h7FF0_0000_0000_0000;
           3: b = 64'hFFF0_0000_0000_0000;
           4: b = 64'h7FF4_0000_0000_0001;
           5: b = 64'h0000_0000_0000_0001;
           default: b = 64'h7FEF_FFFF_FFFF_FFFF;
         endcase
      8: b[62:52] = 11'd0;
      default: b[62:52] = 11'(2046 - $urandom_range(0, 3));
    endcase
    return b;
  endfunction

  task automatic random_item();
    int pick;
    logic [11:0] pos;
    pick = $urandom_range(0, 99);
    if (pick < 20 || loaded_pos.size() == 0) begin
      // half of the loads reuse a small window so vector entries get rewritten
      pos = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 31)) : 12'($urandom);
      send_req(REQ_LOAD, pos, rand_double(), 1'($urandom));
    end else if (pick < 84) begin
      pos = 12'(loaded_pos[$urandom_range(0, loaded_pos.size() - 1)]);
      send_req(REQ_NONZERO, pos, rand_double(), ($urandom_range(0, 99) < 35));
    end else if (pick < 97) begin
      send_req(REQ_EMPTY, 12'($urandom), {$urandom, $urandom}, 1'($urandom));
    end else begin
      send_req(REQ_UNUSED, 12'($urandom), {$urandom, $urandom}, 1'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [12:0] row_settings[8];
    row_settings = '{13'd1, 13'd0, 13'd3, 13'd4096, 13'd8191, 13'd2, 13'd17, 13'd4096};
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_LOAD;
    position = 12'd0;
    payload = 64'd0;
    row_end = 1'b0;
    cfg_valid = 1'b0;
    cfg_rows = 13'd0;
    hold_req = 1'b0;
    items_sent = 0;
    burst_left = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    write_rows(13'd4);

    // directed: special values, store extremes, rounding, partial-row discard
    send_req(REQ_LOAD, 12'd0, 64'h3FF0_0000_0000_0000, 1'b0);
    send_req(REQ_LOAD, 12'd4095, 64'hC000_0000_0000_0000, 1'b1);
    send_req(REQ_LOAD, 12'd1, 64'h8000_0000_0000_0000, 1'b0);
    send_req(REQ_LOAD, 12'd2, 64'h7FF0_0000_0000_0000, 1'b0);
    send_req(REQ_LOAD, 12'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_req(REQ_LOAD, 12'd5, 64'h0000_0000_0000_0001, 1'b0);
    send_req(REQ_LOAD, 12'd6, 64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    send_req(REQ_NONZERO, 12'd0, 64'h4008_0000_0000_0000, 1'b1);
    send_req(REQ_NONZERO, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_req(REQ_NONZERO, 12'd6, 64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    send_req(REQ_NONZERO, 12'd6, 64'h3FF0_0000_0000_0000, 1'b1);
    send_req(REQ_NONZERO, 12'd2, 64'h0000_0000_0000_0000, 1'b1);
    send_req(REQ_EMPTY, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_req(REQ_NONZERO, 12'd5, 64'h3FE0_0000_0000_0000, 1'b1);
    send_req(REQ_NONZERO, 12'd0, 64'h3FF0_0000_0000_0000, 1'b0);
    send_req(REQ_EMPTY, 12'd0, 64'd0, 1'b0);
    send_req(REQ_UNUSED, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_req(REQ_NONZERO, 12'd1, 64'hBFF0_0000_0000_0000, 1'b1);
    send_req(REQ_NONZERO, 12'd3, 64'h3FF0_0000_0000_0000, 1'b0);
    send_req(REQ_NONZERO, 12'd0, 64'h4000_0000_0000_0000, 1'b1);

    foreach (row_settings[p]) begin
      write_rows(row_settings[p]);
      // hold the receiver off for a long stretch while items keep coming
      if (p == 3) hold_req = 1'b1;
      repeat (125) random_item();
    end

    in_valid = 1'b0;
    while (pending_rows != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Sent %0d items over %0d row count settings; %0d rows compared.",
             items_sent, 9, rows_checked);
    $display("Covered special doubles, partial-row discard, row wrap and a long output hold.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
